[hw/rtl/xbl_pkg.sv]
// xbl_pkg: shared types, constants and the character map of the keyed
// base64url line encoder
// no dependencies
package xbl_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_WORD   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH = 1'b1;

    // register reset values
    localparam logic [15:0] KEY_WORD_RST   = 16'h07D2;
    localparam logic [7:0]  LINE_WIDTH_RST = 8'd76;
    localparam int unsigned LINE_W_BITS    = 8;

    // character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;

    // results per input byte
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned RES_IDX  = 2;
    localparam int unsigned RES_CNT  = 3;

    // position inside a three-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // one output character with its end flag
    typedef struct packed {
        logic [7:0] ch;
        logic       msg_end;
    } t_entry;

    // all results of one byte
    typedef struct packed {
        t_entry [MAX_RES-1:0] ent;
        logic [RES_CNT-1:0]   cnt;
    } t_expand;

    // url-safe base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = CHAR_UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            r = CHAR_LOWER_A + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = CHAR_DIGIT_0 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = CHAR_DASH;
        end else begin
            r = CHAR_UNDER;
        end
        return r;
    endfunction

endpackage

[hw/rtl/xbl_cfg_regs.sv]
// xbl_cfg_regs: key and line width registers behind the write port
// depends on xbl_pkg
module xbl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xbl_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                      i_cfg_data,
    output logic [15:0]                      o_key_word,
    output logic [xbl_pkg::LINE_W_BITS-1:0]  o_line_width
);
    import xbl_pkg::*;

    logic [15:0]            r_key_word;
    logic [LINE_W_BITS-1:0] r_line_width;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word   <= KEY_WORD_RST;
            r_line_width <= LINE_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_WORD:   r_key_word   <= i_cfg_data;
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LINE_W_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_key_word   = r_key_word;
    assign o_line_width = r_line_width;

endmodule

[hw/rtl/xbl_expand.sv]
// xbl_expand: stream state and the expansion of one byte into its characters
// depends on xbl_pkg
module xbl_expand #(
    parameter int unsigned COLUMN_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    input  logic [15:0]                     i_key_word,
    input  logic [xbl_pkg::LINE_W_BITS-1:0] i_line_width,
    output xbl_pkg::t_expand                o_exp
);
    import xbl_pkg::*;

    localparam int unsigned CMP_W =
        (COLUMN_BITS > LINE_W_BITS) ? COLUMN_BITS : LINE_W_BITS;

    t_phase                 r_phase,  n_phase;
    logic [3:0]             r_left,   n_left;
    logic                   r_parity, n_parity;
    logic [COLUMN_BITS-1:0] r_col,    n_col;

    logic [7:0]             kb;
    logic [7:0]             b;
    logic [5:0]             sa;
    logic [5:0]             sb;
    logic                   has_b;
    logic [COLUMN_BITS-1:0] col_a;
    logic [COLUMN_BITS-1:0] col_ma;
    logic [COLUMN_BITS-1:0] col_b;
    logic                   nl_a;
    logic                   nl_b;
    logic                   tail_nl;
    logic [RES_CNT-1:0]     n;
    logic [RES_CNT-1:0]     n_tail;
    t_expand                exp_c;

    // xor with key, split into sextets
    always_comb begin
        kb    = r_parity ? i_key_word[7:0] : i_key_word[15:8];
        b     = i_data_byte ^ kb;
        sa    = 6'd0;
        sb    = 6'd0;
        has_b = 1'b0;
        n_left  = 4'd0;
        n_phase = PH_0;
        case (r_phase)
            PH_0: begin
                sa      = b[7:2];
                sb      = {b[1:0], 4'b0000};
                has_b   = i_last_byte;
                n_left  = {2'b00, b[1:0]};
                n_phase = PH_1;
            end
            PH_1: begin
                sa      = {r_left[1:0], b[7:4]};
                sb      = {b[3:0], 2'b00};
                has_b   = i_last_byte;
                n_left  = b[3:0];
                n_phase = PH_2;
            end
            PH_2: begin
                sa      = {r_left, b[7:6]};
                sb      = b[5:0];
                has_b   = 1'b1;
                n_left  = 4'd0;
                n_phase = PH_0;
            end
            default: begin
                sa      = 6'd0;
                sb      = 6'd0;
                has_b   = 1'b0;
                n_left  = 4'd0;
                n_phase = PH_0;
            end
        endcase
    end

    // column tracking and line breaks
    always_comb begin
        col_a  = r_col + 1'b1;
        nl_a   = CMP_W'(col_a) >= CMP_W'(i_line_width);
        col_ma = nl_a ? '0 : col_a;
        col_b  = col_ma + 1'b1;
        nl_b   = CMP_W'(col_b) >= CMP_W'(i_line_width);
        if (has_b) begin
            n_col = nl_b ? '0 : col_b;
        end else begin
            n_col = col_ma;
        end
    end

    // pack the character list
    always_comb begin
        exp_c   = '0;
        n       = '0;
        tail_nl = 1'b0;
        exp_c.ent[n[RES_IDX-1:0]].ch = b64_char(sa);
        n       = n + 1'b1;
        if (nl_a) begin
            exp_c.ent[n[RES_IDX-1:0]].ch = CHAR_NEWLINE;
            n       = n + 1'b1;
            tail_nl = 1'b1;
        end
        if (has_b) begin
            exp_c.ent[n[RES_IDX-1:0]].ch = b64_char(sb);
            n       = n + 1'b1;
            tail_nl = 1'b0;
            if (nl_b) begin
                exp_c.ent[n[RES_IDX-1:0]].ch = CHAR_NEWLINE;
                n       = n + 1'b1;
                tail_nl = 1'b1;
            end
        end
        n_tail = n - 1'b1;
        if (i_last_byte) begin
            if (tail_nl) begin
                exp_c.ent[n_tail[RES_IDX-1:0]].msg_end = 1'b1;
            end else begin
                exp_c.ent[n[RES_IDX-1:0]].ch      = CHAR_NEWLINE;
                exp_c.ent[n[RES_IDX-1:0]].msg_end = 1'b1;
                n = n + 1'b1;
            end
        end
        exp_c.cnt = n;
    end

    assign o_exp    = exp_c;
    assign n_parity = ~r_parity;

    // stream state, back to reset after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_0;
            r_left   <= 4'd0;
            r_parity <= 1'b0;
            r_col    <= '0;
        end else if (i_adv) begin
            if (i_last_byte) begin
                r_phase  <= PH_0;
                r_left   <= 4'd0;
                r_parity <= 1'b0;
                r_col    <= '0;
            end else begin
                r_phase  <= n_phase;
                r_left   <= n_left;
                r_parity <= n_parity;
                r_col    <= n_col;
            end
        end
    end

endmodule

[hw/rtl/xbl_out_buf.sv]
// xbl_out_buf: result buffer holding one byte's characters, sent one per cycle unless stalled
// depends on xbl_pkg
module xbl_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  xbl_pkg::t_expand i_exp,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_char,
    output logic             o_run_last,
    output logic             o_message_end
);
    import xbl_pkg::*;

    t_entry [MAX_RES-1:0] r_ent;
    logic [RES_CNT-1:0]   r_cnt;
    logic [RES_IDX-1:0]   r_rd_idx;
    logic                 r_valid;
    logic                 is_last;
    logic                 take;
    logic [RES_CNT-1:0]   cnt_m1;

    assign cnt_m1  = r_cnt - 1'b1;
    assign is_last = ({1'b0, r_rd_idx} == cnt_m1);
    assign take    = r_valid && !i_out_stall;
    assign o_free  = !r_valid || (take && is_last);

    // control: fill on load, step on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_rd_idx <= '0;
        end else if (i_load) begin
            r_valid  <= 1'b1;
            r_rd_idx <= '0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_exp.ent;
            r_cnt <= i_exp.cnt;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_char    = r_ent[r_rd_idx].ch;
    assign o_message_end = r_ent[r_rd_idx].msg_end;
    assign o_run_last    = is_last;

    // checks
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_rd_idx} < r_cnt))
        else $error("read index past character count");
    a_end_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_message_end) |-> (o_run_last && o_out_char == CHAR_NEWLINE))
        else $error("message end not on final newline");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("buffer loaded while still busy");
    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_rd_idx == '0))
        else $error("load did not restart the buffer");

endmodule

[hw/rtl/xor_base64url_line_encoder_top.sv]
// a taken byte is held in the input register, then its characters go to the result buffer
// throughput: one output character per cycle while not stalled, so a byte gives 1 to 4
// characters (about 1.33 plus newlines on average), set by the single output character port
// a new byte is taken every cycle its predecessor's last character leaves
// reset: synchronous active-low; clears stream state and buffers, key 0x07D2, width 76
module xor_base64url_line_encoder_top #(
    parameter int unsigned COLUMN_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_out_char,
    output logic                             o_run_last,
    output logic                             o_message_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [xbl_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import xbl_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic [15:0]            key_word;
    logic [LINE_W_BITS-1:0] line_width;
    logic                   buf_free;
    logic                   adv;
    logic                   in_take;
    t_expand                exp_w;

    // configuration registers
    xbl_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_key_word   (key_word),
        .o_line_width (line_width)
    );

    // input register handshake
    assign adv        = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !buf_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // byte to character list
    xbl_expand #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_expand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_key_word   (key_word),
        .i_line_width (line_width),
        .o_exp        (exp_w)
    );

    // result buffer and output port
    xbl_out_buf u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (adv),
        .i_exp         (exp_w),
        .o_free        (buf_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule
